/* rtl/core/fcs_pkg.sv */
`default_nettype none

package fcs_pkg;

	localparam int MAX_RADIUS_DEF = 7;
	localparam int SCORE_BITS_DEF = 32;

	localparam int SCORE_W    = 32;
	localparam int DISP_W     = 4;
	localparam int SUMSQ_W    = 12;
	localparam int NSUM_W     = 9;
	localparam int NCNT_W     = 5;
	localparam int RAD_W      = 3;
	localparam int WEIGHT_W   = 20;
	localparam int CFG_DATA_W = 20;
	localparam int CFG_IDX_W  = 2;

	localparam logic [CFG_IDX_W-1:0] REG_WINDOW_RADIUS = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SMOOTHING_ON  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_SMOOTH_WEIGHT = 2'd2;

	localparam logic [RAD_W-1:0]    RADIUS_RST    = 3'd2;
	localparam logic                SMOOTH_ON_RST = 1'b0;
	localparam logic [WEIGHT_W-1:0] WEIGHT_RST    = 20'd65536;

	// distance penalty is 0.001 * d2 in q16.16, rounded half up
	localparam int FRAC_BITS = 16;
	localparam int DIST_DIV  = 1000;
	localparam int DIST_RND  = 500;
	localparam int DIV_GUARD = 10;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PROD,
		ST_MUL,
		ST_COST,
		ST_SUM,
		ST_DECIDE
	} fcs_state_t;

	typedef struct packed {
		logic capture;
		logic decide;
	} fcs_cmd_t;

	typedef struct packed {
		logic emits;
		logic out_stall;
	} fcs_sts_t;

	typedef struct packed {
		logic [SCORE_W-1:0] match_score;
		logic               target_in_grid;
		logic               target_claimed;
		logic [SCORE_W-1:0] claim_score;
		logic               own_flow_valid;
		logic [DISP_W-1:0]  own_u;
		logic [DISP_W-1:0]  own_v;
		logic [SUMSQ_W-1:0] neighbour_sum_sq;
		logic [NSUM_W-1:0]  neighbour_sum_u;
		logic [NSUM_W-1:0]  neighbour_sum_v;
		logic [NCNT_W-1:0]  neighbour_count;
		logic               column_empty;
	} fcs_cand_t;

	typedef struct packed {
		logic [DISP_W-1:0]  best_u;
		logic [DISP_W-1:0]  best_v;
		logic               flow_valid;
		logic [SCORE_W-1:0] flow_score;
	} fcs_res_t;

endpackage

`default_nettype wire

/* rtl/core/fcs_in_if.sv */
`default_nettype none

interface fcs_in_if;
	logic                               valid;
	logic                               ready;
	logic signed [fcs_pkg::SCORE_W-1:0] match_score;
	logic                               target_in_grid;
	logic                               target_claimed;
	logic signed [fcs_pkg::SCORE_W-1:0] claim_score;
	logic                               own_flow_valid;
	logic signed [fcs_pkg::DISP_W-1:0]  own_u;
	logic signed [fcs_pkg::DISP_W-1:0]  own_v;
	logic [fcs_pkg::SUMSQ_W-1:0]        neighbour_sum_sq;
	logic signed [fcs_pkg::NSUM_W-1:0]  neighbour_sum_u;
	logic signed [fcs_pkg::NSUM_W-1:0]  neighbour_sum_v;
	logic [fcs_pkg::NCNT_W-1:0]         neighbour_count;
	logic                               column_empty;

	modport source (
		output valid, match_score, target_in_grid, target_claimed, claim_score,
		output own_flow_valid, own_u, own_v, neighbour_sum_sq, neighbour_sum_u,
		output neighbour_sum_v, neighbour_count, column_empty,
		input  ready
	);

	modport sink (
		input  valid, match_score, target_in_grid, target_claimed, claim_score,
		input  own_flow_valid, own_u, own_v, neighbour_sum_sq, neighbour_sum_u,
		input  neighbour_sum_v, neighbour_count, column_empty,
		output ready
	);
endinterface

`default_nettype wire

/* rtl/core/fcs_out_if.sv */
`default_nettype none

interface fcs_out_if;
	logic                               valid;
	logic                               ready;
	logic signed [fcs_pkg::DISP_W-1:0]  best_u;
	logic signed [fcs_pkg::DISP_W-1:0]  best_v;
	logic                               flow_valid;
	logic signed [fcs_pkg::SCORE_W-1:0] flow_score;

	modport source (
		output valid, best_u, best_v, flow_valid, flow_score,
		input  ready
	);

	modport sink (
		input  valid, best_u, best_v, flow_valid, flow_score,
		output ready
	);
endinterface

`default_nettype wire

/* rtl/core/fcs_ctrl.sv */
`default_nettype none

module fcs_ctrl (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	input  fcs_pkg::fcs_sts_t      sts,
	output fcs_pkg::fcs_cmd_t      cmd,
	output logic                   in_ready
);

	fcs_pkg::fcs_state_t state_q;
	fcs_pkg::fcs_state_t state_next;
	logic                blocked;

	assign blocked = sts.emits && sts.out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= fcs_pkg::ST_IDLE;
		end else begin
			state_q <= state_next;
		end
	end

	always_comb begin
		state_next = state_q;
		unique case (state_q)
			fcs_pkg::ST_IDLE: begin
				if (in_valid) begin
					state_next = fcs_pkg::ST_PROD;
				end
			end
			fcs_pkg::ST_PROD:   state_next = fcs_pkg::ST_MUL;
			fcs_pkg::ST_MUL:    state_next = fcs_pkg::ST_COST;
			fcs_pkg::ST_COST:   state_next = fcs_pkg::ST_SUM;
			fcs_pkg::ST_SUM:    state_next = fcs_pkg::ST_DECIDE;
			fcs_pkg::ST_DECIDE: begin
				if (!blocked) begin
					state_next = fcs_pkg::ST_IDLE;
				end
			end
			default:            state_next = fcs_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		cmd.capture = 1'b0;
		cmd.decide  = 1'b0;
		in_ready    = 1'b0;
		unique case (state_q)
			fcs_pkg::ST_IDLE: begin
				in_ready    = 1'b1;
				cmd.capture = in_valid;
			end
			fcs_pkg::ST_DECIDE: begin
				cmd.decide = !blocked;
			end
			default: begin
				in_ready = 1'b0;
			end
		endcase
	end

	// a finished result never overwrites one still waiting
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.decide |-> !(sts.emits && sts.out_stall))
		else $error("decide issued while result register is stalled");

	// one transaction in flight at a time
	a_single_item: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.capture |=> !in_ready ##4 !in_ready)
		else $error("new transaction taken while a candidate is in flight");

	a_decide_done: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.decide |=> state_q == fcs_pkg::ST_IDLE)
		else $error("controller did not return to idle after decide");

endmodule

`default_nettype wire

/* rtl/core/fcs_datapath.sv */
`default_nettype none

module fcs_datapath #(
	parameter int MAX_RADIUS = fcs_pkg::MAX_RADIUS_DEF,
	parameter int SCORE_BITS = fcs_pkg::SCORE_BITS_DEF
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              cfg_wr_en,
	input  wire logic [fcs_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  wire logic [fcs_pkg::CFG_DATA_W-1:0]    cfg_data,
	input  fcs_pkg::fcs_cand_t                     cand_data,
	input  fcs_pkg::fcs_cmd_t                      cmd,
	output fcs_pkg::fcs_sts_t                      sts,
	input  wire logic                              res_ready,
	output logic                                   res_valid,
	output fcs_pkg::fcs_res_t                      res_data
);

	localparam int OFF_W   = $clog2(MAX_RADIUS + 1) + 1;
	localparam int D2_W    = 2 * OFF_W - 1;
	localparam int PU_W    = OFF_W + fcs_pkg::NSUM_W;
	localparam int S_W     = 2 * OFF_W + 10;
	localparam int CD_W    = D2_W + fcs_pkg::NCNT_W;
	localparam int X_W     = D2_W + fcs_pkg::FRAC_BITS + 1;
	localparam int RSH     = X_W + fcs_pkg::DIV_GUARD;
	localparam int RCP_W   = X_W + 1;
	localparam int PP_W    = X_W + RCP_W;
	localparam int PEN_W   = PP_W - RSH;
	localparam int COST_W  = S_W + fcs_pkg::WEIGHT_W + 1;
	localparam int BASE_W  = (COST_W > fcs_pkg::SCORE_W) ? COST_W : fcs_pkg::SCORE_W;
	localparam int SUM_W   = ((BASE_W > SCORE_BITS) ? BASE_W : SCORE_BITS) + 2;
	localparam int RST_R   = (int'(fcs_pkg::RADIUS_RST) > MAX_RADIUS) ?
		MAX_RADIUS : int'(fcs_pkg::RADIUS_RST);

	localparam logic [63:0] RECIP_FULL =
		((64'd1 << RSH) + 64'(fcs_pkg::DIST_DIV) - 64'd1) / 64'(fcs_pkg::DIST_DIV);
	localparam logic [RCP_W-1:0] RECIP = RCP_W'(RECIP_FULL);

	localparam logic signed [SUM_W-1:0] SAT_HI = (SUM_W'(1) <<< (SCORE_BITS - 1)) - SUM_W'(1);
	localparam logic signed [SUM_W-1:0] SAT_LO = -SAT_HI - SUM_W'(1);
	localparam logic signed [OFF_W-1:0] OFF_RST = OFF_W'(-RST_R);

	// configuration
	logic [fcs_pkg::RAD_W-1:0]    radius_q;
	logic                         smooth_on_q;
	logic [fcs_pkg::WEIGHT_W-1:0] weight_q;

	// run state
	logic signed [OFF_W-1:0]      row_off_q;
	logic signed [OFF_W-1:0]      col_off_q;
	logic signed [SCORE_BITS-1:0] top_score_q;
	logic signed [OFF_W-1:0]      best_u_q;
	logic signed [OFF_W-1:0]      best_v_q;
	logic                         run_valid_q;

	fcs_pkg::fcs_cand_t           cand_q;

	// score pipeline
	logic [D2_W-1:0]              d2_s1;
	logic signed [PU_W-1:0]       pu_s1;
	logic signed [PU_W-1:0]       pv_s1;
	logic signed [S_W-1:0]        s_s2;
	logic [PP_W-1:0]              pen_prod_s2;
	logic signed [COST_W-1:0]     cost_s3;
	logic [PEN_W-1:0]             pen_s3;
	logic signed [SCORE_BITS-1:0] score_s4;

	logic                         res_valid_q;
	fcs_pkg::fcs_res_t            res_q;

	logic [fcs_pkg::RAD_W-1:0]    rad_c;
	logic [fcs_pkg::RAD_W-1:0]    cfg_rad_c;
	logic signed [OFF_W-1:0]      r_s;
	logic signed [OFF_W-1:0]      cfg_r_s;
	logic signed [2*OFF_W-1:0]    sq_u;
	logic signed [2*OFF_W-1:0]    sq_v;
	logic [CD_W-1:0]              cd;
	logic signed [S_W-1:0]        s_next;
	logic [X_W-1:0]               x;
	logic signed [COST_W-1:0]     cost_sel;
	logic signed [SUM_W-1:0]      raw;
	logic signed [SUM_W-1:0]      sat;
	logic                         beats_best;
	logic                         beats_claim;
	logic                         own_here;
	logic                         take;
	logic                         last;
	logic                         restart_cfg;
	logic signed [SCORE_BITS-1:0] new_score;
	logic signed [OFF_W-1:0]      new_u;
	logic signed [OFF_W-1:0]      new_v;
	logic                         new_valid;

	// radius clamp, current and incoming
	always_comb begin
		rad_c     = (int'(radius_q) > MAX_RADIUS) ? fcs_pkg::RAD_W'(MAX_RADIUS) : radius_q;
		cfg_rad_c = (int'(cfg_data[fcs_pkg::RAD_W-1:0]) > MAX_RADIUS) ?
			fcs_pkg::RAD_W'(MAX_RADIUS) : cfg_data[fcs_pkg::RAD_W-1:0];
		r_s       = OFF_W'($signed({1'b0, rad_c}));
		cfg_r_s   = OFF_W'($signed({1'b0, cfg_rad_c}));
	end

	assign restart_cfg = cfg_wr_en && (cfg_index == fcs_pkg::REG_WINDOW_RADIUS);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radius_q    <= fcs_pkg::RADIUS_RST;
			smooth_on_q <= fcs_pkg::SMOOTH_ON_RST;
			weight_q    <= fcs_pkg::WEIGHT_RST;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				fcs_pkg::REG_WINDOW_RADIUS: radius_q <= cfg_data[fcs_pkg::RAD_W-1:0];
				fcs_pkg::REG_SMOOTHING_ON:  smooth_on_q <= cfg_data[0];
				fcs_pkg::REG_SMOOTH_WEIGHT: weight_q <= cfg_data[fcs_pkg::WEIGHT_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			cand_q <= cand_data;
		end
	end

	// stage 1: squares and neighbour products
	always_comb begin
		sq_u = (2*OFF_W)'(row_off_q) * (2*OFF_W)'(row_off_q);
		sq_v = (2*OFF_W)'(col_off_q) * (2*OFF_W)'(col_off_q);
	end

	// stage 2: smoothness sum and penalty reciprocal multiply
	always_comb begin
		cd     = CD_W'(d2_s1) * CD_W'(cand_q.neighbour_count);
		s_next = S_W'($signed({1'b0, cand_q.neighbour_sum_sq}))
			+ S_W'($signed({1'b0, cd}))
			- ((S_W'(pu_s1) + S_W'(pv_s1)) <<< 1);
		x      = X_W'({d2_s1, fcs_pkg::FRAC_BITS'(0)}) + X_W'(fcs_pkg::DIST_RND);
	end

	// stage 4: saturating sum
	always_comb begin
		cost_sel = smooth_on_q ? cost_s3 : COST_W'(0);
		raw = SUM_W'($signed(cand_q.match_score))
			- SUM_W'($signed({1'b0, pen_s3}))
			- SUM_W'(cost_sel);
		priority if (raw > SAT_HI) begin
			sat = SAT_HI;
		end else if (raw < SAT_LO) begin
			sat = SAT_LO;
		end else begin
			sat = raw;
		end
	end

	always_ff @(posedge clk) begin
		d2_s1       <= D2_W'(sq_u + sq_v);
		pu_s1       <= PU_W'(row_off_q) * PU_W'($signed(cand_q.neighbour_sum_u));
		pv_s1       <= PU_W'(col_off_q) * PU_W'($signed(cand_q.neighbour_sum_v));
		s_s2        <= s_next;
		pen_prod_s2 <= PP_W'(x) * PP_W'(RECIP);
		cost_s3     <= COST_W'(s_s2) * COST_W'($signed({1'b0, weight_q}));
		pen_s3      <= PEN_W'(pen_prod_s2 >> RSH);
		score_s4    <= SCORE_BITS'(sat);
	end

	// running best update
	always_comb begin
		beats_best  = (score_s4 > top_score_q) || !run_valid_q;
		beats_claim = score_s4 > $signed(cand_q.claim_score);
		own_here    = cand_q.own_flow_valid
			&& ($signed(cand_q.own_u) == row_off_q)
			&& ($signed(cand_q.own_v) == col_off_q);
		take        = cand_q.target_in_grid && beats_best
			&& (!cand_q.target_claimed || beats_claim || own_here);
		last        = (row_off_q >= r_s) && (col_off_q >= r_s);
		new_score   = take ? score_s4 : top_score_q;
		new_u       = take ? row_off_q : best_u_q;
		new_v       = take ? col_off_q : best_v_q;
		new_valid   = take || run_valid_q;
	end

	assign sts.emits     = cand_q.column_empty || last;
	assign sts.out_stall = res_valid_q && !res_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_off_q    <= OFF_RST;
			col_off_q    <= OFF_RST;
			top_score_q  <= '0;
			best_u_q     <= '0;
			best_v_q     <= '0;
			run_valid_q  <= 1'b0;
		end else if (restart_cfg) begin
			row_off_q    <= -cfg_r_s;
			col_off_q    <= -cfg_r_s;
			top_score_q  <= '0;
			best_u_q     <= '0;
			best_v_q     <= '0;
			run_valid_q  <= 1'b0;
		end else if (cmd.decide) begin
			if (sts.emits) begin
				row_off_q    <= -r_s;
				col_off_q    <= -r_s;
				top_score_q  <= '0;
				best_u_q     <= '0;
				best_v_q     <= '0;
				run_valid_q  <= 1'b0;
			end else begin
				top_score_q  <= new_score;
				best_u_q     <= new_u;
				best_v_q     <= new_v;
				run_valid_q  <= new_valid;
				if (col_off_q >= r_s) begin
					col_off_q <= -r_s;
					row_off_q <= row_off_q + OFF_W'(1);
				end else begin
					col_off_q <= col_off_q + OFF_W'(1);
				end
			end
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (cmd.decide && sts.emits) begin
			res_valid_q <= 1'b1;
		end else if (res_ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.decide && sts.emits) begin
			if (cand_q.column_empty) begin
				res_q <= '0;
			end else begin
				res_q.best_u     <= fcs_pkg::DISP_W'(new_u);
				res_q.best_v     <= fcs_pkg::DISP_W'(new_v);
				res_q.flow_valid <= new_valid;
				res_q.flow_score <= fcs_pkg::SCORE_W'(new_score);
			end
		end
	end

	assign res_valid = res_valid_q;
	assign res_data  = res_q;

	a_offsets_in_window: assert property (@(posedge clk) disable iff (!arst_n)
		(row_off_q >= -r_s) && (row_off_q <= r_s)
		&& (col_off_q >= -r_s) && (col_off_q <= r_s))
		else $error("candidate offsets left the search window");

	a_result_from_decide: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(res_valid_q) |-> $past(cmd.decide) && $past(sts.emits))
		else $error("result appeared without a window end or empty column");

	a_invalid_is_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid_q && !res_q.flow_valid) |->
		(res_q.best_u == '0) && (res_q.best_v == '0) && (res_q.flow_score == '0))
		else $error("invalid flow result carries nonzero fields");

endmodule

`default_nettype wire

/* rtl/core/flow_candidate_select_unit.sv */
`default_nettype none

// Running best-displacement selection for one grid column. Candidates of a
// (2R+1)x(2R+1) window arrive in row-major order of (du,dv); the block tracks
// the offsets itself, scores each candidate (match score minus distance
// penalty, minus weighted smoothness cost when enabled, saturated to
// SCORE_BITS) and keeps the best legal one. The last candidate of the window,
// or any item flagged as an empty column, produces one result transaction.
// From acceptance until ready again, a candidate passes an accept step, four
// stages of score arithmetic (squares and neighbour products, penalty
// reciprocal multiply, weight multiply, saturating sum) and a running-best
// update, which waits if it emits while an earlier result sits unaccepted
// in the output register. Writing window_radius restarts the window; the
// user writes configuration only while idle; the block does not enforce it.

module flow_candidate_select_unit #(
	parameter int MAX_RADIUS = fcs_pkg::MAX_RADIUS_DEF,
	parameter int SCORE_BITS = fcs_pkg::SCORE_BITS_DEF
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           cfg_wr_en,
	input  wire logic [fcs_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [fcs_pkg::CFG_DATA_W-1:0] cfg_data,
	fcs_in_if.sink                              cand,
	fcs_out_if.source                           result
);

	fcs_pkg::fcs_cmd_t  cmd;
	fcs_pkg::fcs_sts_t  sts;
	fcs_pkg::fcs_cand_t cand_data;
	fcs_pkg::fcs_res_t  res_data;
	logic               in_ready;
	logic               res_valid;

	always_comb begin
		cand_data.match_score      = cand.match_score;
		cand_data.target_in_grid   = cand.target_in_grid;
		cand_data.target_claimed   = cand.target_claimed;
		cand_data.claim_score      = cand.claim_score;
		cand_data.own_flow_valid   = cand.own_flow_valid;
		cand_data.own_u            = cand.own_u;
		cand_data.own_v            = cand.own_v;
		cand_data.neighbour_sum_sq = cand.neighbour_sum_sq;
		cand_data.neighbour_sum_u  = cand.neighbour_sum_u;
		cand_data.neighbour_sum_v  = cand.neighbour_sum_v;
		cand_data.neighbour_count  = cand.neighbour_count;
		cand_data.column_empty     = cand.column_empty;
	end

	fcs_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (cand.valid),
		.sts      (sts),
		.cmd      (cmd),
		.in_ready (in_ready)
	);

	fcs_datapath #(
		.MAX_RADIUS (MAX_RADIUS),
		.SCORE_BITS (SCORE_BITS)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cand_data (cand_data),
		.cmd       (cmd),
		.sts       (sts),
		.res_ready (result.ready),
		.res_valid (res_valid),
		.res_data  (res_data)
	);

	assign cand.ready        = in_ready;
	assign result.valid      = res_valid;
	assign result.best_u     = res_data.best_u;
	assign result.best_v     = res_data.best_v;
	assign result.flow_valid = res_data.flow_valid;
	assign result.flow_score = res_data.flow_score;

endmodule

`default_nettype wire
